/* rtl/smns_pkg.sv */
package smns_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int DIM_W         = 12;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [DIM_W-1:0] DIM_MIN    = 12'd3;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // direction bins
    localparam logic [1:0] DIR_HORIZ = 2'd0;
    localparam logic [1:0] DIR_VERT  = 2'd1;
    localparam logic [1:0] DIR_DIAG_MAIN = 2'd2;
    localparam logic [1:0] DIR_DIAG_ANTI = 2'd3;

    // tan(22.5) and tan(67.5) in 8-bit fraction
    localparam logic [9:0] TAN_LOW  = 10'd106;
    localparam logic [9:0] TAN_HIGH = 10'd618;

    localparam logic [7:0] MAG_SAT = 8'd255;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       is_pixel;
        logic [7:0] pixel;
    } slot_t;

    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } pos_t;

    function automatic pos_t advance(input pos_t p, input logic [DIM_W-1:0] w,
                                     input logic [DIM_W-1:0] h);
        pos_t n;
        n = p;
        if ({1'b0, p.col} + 13'd1 >= {1'b0, w}) begin
            n.col = '0;
            if ({1'b0, p.row} + 13'd1 >= {1'b0, h}) begin
                n.row = '0;
            end
            else begin
                n.row = p.row + 12'd1;
            end
        end
        else begin
            n.col = p.col + 12'd1;
        end
        return n;
    endfunction

    function automatic logic interior(input pos_t p, input logic [DIM_W-1:0] w,
                                      input logic [DIM_W-1:0] h);
        return (p.row != '0) && ({1'b0, p.row} + 13'd2 <= {1'b0, h})
            && (p.col != '0) && ({1'b0, p.col} + 13'd2 <= {1'b0, w});
    endfunction

endpackage

/* rtl/smns_ram.sv */
module smns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/smns_front.sv */
module smns_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [smns_pkg::DIM_W-1:0]   w,
    input  logic [smns_pkg::DIM_W-1:0]   h,
    input  logic                         clearing,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  smns_pkg::in_item_t           in_item,
    output logic                         q_valid,
    output smns_pkg::slot_t              q_item,
    input  logic                         q_pop
);

    smns_pkg::pos_t  in_pos_reg;
    smns_pkg::slot_t q_mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    logic accept;
    logic is_pixel;
    logic push;

    assign in_stall = clearing || (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign is_pixel = (in_item.kind == smns_pkg::KIND_PIXEL);
    // drop a flush that lands inside a frame
    assign push     = accept && (is_pixel || (in_pos_reg == '0));

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pos_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept && is_pixel)
            begin
                in_pos_reg <= smns_pkg::advance(in_pos_reg, w, h);
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg].is_pixel <= is_pixel;
            q_mem_reg[wr_ptr_reg].pixel    <= is_pixel ? in_item.pixel : 8'd0;
        end
    end

endmodule

/* rtl/smns_back.sv */
module smns_back #(
    parameter int MAX_WIDTH = smns_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [smns_pkg::DIM_W-1:0]   w,
    input  logic [smns_pkg::DIM_W-1:0]   h,
    output logic                         clearing,
    input  logic                         q_valid,
    input  smns_pkg::slot_t              q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output smns_pkg::out_item_t          out_item
);

    localparam int RING_DEPTH = 3 * MAX_WIDTH + 4;
    localparam int AW         = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] RING_LAST = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   RING_SIZE = (AW+1)'(RING_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PRD, ST_GRAD, ST_SQ, ST_SQRT, ST_MWR, ST_MRD, ST_OUT
    } state_t;

    function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] p,
                                              input logic [AW-1:0] k);
        logic [AW:0] diff;
        diff = {1'b0, p} - {1'b0, k};
        if (p < k)
        begin
            diff = diff + RING_SIZE;
        end
        return diff[AW-1:0];
    endfunction

    state_t              state_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       off_reg;
    logic [1:0]          dc_reg;
    logic [3:0]          idx_reg;
    logic                cap_en_reg;
    logic                cap_mag_reg;
    logic [3:0]          cap_idx_reg;
    logic [2:0]          bit_reg;
    smns_pkg::pos_t      mag_pos_reg;
    smns_pkg::pos_t      out_pos_reg;
    logic                out_valid_reg;
    smns_pkg::out_item_t out_item_reg;

    logic [7:0]          p_reg [9];
    logic [9:0]          m_reg [9];
    logic                vc_reg;
    logic                vo_reg;
    logic signed [10:0]  gx_reg;
    logic signed [10:0]  gy_reg;
    logic [20:0]         s_reg;
    logic                sat_reg;
    logic [1:0]          dir_reg;
    logic [7:0]          root_reg;

    logic [AW-1:0]       w_a;
    logic [AW-1:0]       ptr_inc;
    logic [AW-1:0]       raddr;
    logic                pix_we;
    logic [AW-1:0]       pix_waddr;
    logic [8:0]          pix_wdata;
    logic [8:0]          pix_rdata;
    logic                mag_we;
    logic [9:0]          mag_wdata;
    logic [9:0]          mag_rdata;
    logic                out_free;
    logic [7:0]          mag_val;
    logic [7:0]          trial;
    logic [15:0]         trial_sq;
    logic [9:0]          ax;
    logic [9:0]          ay;
    logic [19:0]         ay_s;
    logic [19:0]         ax_lo;
    logic [19:0]         ax_hi;
    logic [1:0]          dir_calc;
    logic [7:0]          nb_a;
    logic [7:0]          nb_b;
    logic [7:0]          centre;
    logic [7:0]          result;
    logic signed [10:0]  gx_calc;
    logic signed [10:0]  gy_calc;

    assign w_a      = AW'(w);
    assign ptr_inc  = (ptr_reg == RING_LAST) ? '0 : ptr_reg + 1'b1;
    assign raddr    = ring_at(ptr_reg, off_reg - AW'(dc_reg));
    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        pix_we    = 1'b0;
        pix_waddr = ptr_inc;
        pix_wdata = {q_item.is_pixel, q_item.pixel};
        if (state_reg == ST_CLEAR)
        begin
            pix_we    = 1'b1;
            pix_waddr = clr_addr_reg;
            pix_wdata = '0;
        end
        else if (q_pop)
        begin
            pix_we = 1'b1;
        end
    end

    assign mag_val   = sat_reg ? smns_pkg::MAG_SAT : root_reg;
    assign mag_we    = (state_reg == ST_MWR) && vc_reg;
    assign mag_wdata = smns_pkg::interior(mag_pos_reg, w, h) ? {dir_reg, mag_val}
                                                             : {2'd0, p_reg[4]};

    smns_ram #(.WIDTH(9), .DEPTH(RING_DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (raddr),
        .rdata (pix_rdata)
    );

    smns_ram #(.WIDTH(10), .DEPTH(RING_DEPTH)) u_mag_ram (
        .clk   (clk),
        .we    (mag_we),
        .waddr (ring_at(ptr_reg, w_a + 1'b1)),
        .wdata (mag_wdata),
        .raddr (raddr),
        .rdata (mag_rdata)
    );

    // gradients, squares and bin
    always_comb
    begin
        gx_calc = (11'(p_reg[2]) + (11'(p_reg[5]) <<< 1) + 11'(p_reg[8]))
                - (11'(p_reg[0]) + (11'(p_reg[3]) <<< 1) + 11'(p_reg[6]));
        gy_calc = (11'(p_reg[6]) + (11'(p_reg[7]) <<< 1) + 11'(p_reg[8]))
                - (11'(p_reg[0]) + (11'(p_reg[1]) <<< 1) + 11'(p_reg[2]));
        ax      = gx_reg[10] ? 10'(-gx_reg) : gx_reg[9:0];
        ay      = gy_reg[10] ? 10'(-gy_reg) : gy_reg[9:0];
        ay_s    = {2'd0, ay, 8'd0};
        ax_lo   = 20'(ax) * 20'(smns_pkg::TAN_LOW);
        ax_hi   = 20'(ax) * 20'(smns_pkg::TAN_HIGH);
        if (ay_s < ax_lo)
        begin
            dir_calc = smns_pkg::DIR_HORIZ;
        end
        else if (ay_s > ax_hi)
        begin
            dir_calc = smns_pkg::DIR_VERT;
        end
        else if ((gx_reg < 0 && gy_reg > 0) || (gx_reg > 0 && gy_reg < 0))
        begin
            dir_calc = smns_pkg::DIR_DIAG_ANTI;
        end
        else
        begin
            dir_calc = smns_pkg::DIR_DIAG_MAIN;
        end
        trial    = root_reg | (8'd1 << bit_reg);
        trial_sq = 16'(trial) * 16'(trial);
    end

    // suppression along the bin
    always_comb
    begin
        centre = m_reg[4][7:0];
        case (m_reg[4][9:8])
            smns_pkg::DIR_HORIZ:
            begin
                nb_a = m_reg[3][7:0];
                nb_b = m_reg[5][7:0];
            end
            smns_pkg::DIR_VERT:
            begin
                nb_a = m_reg[1][7:0];
                nb_b = m_reg[7][7:0];
            end
            smns_pkg::DIR_DIAG_MAIN:
            begin
                nb_a = m_reg[0][7:0];
                nb_b = m_reg[8][7:0];
            end
            default:
            begin
                nb_a = m_reg[2][7:0];
                nb_b = m_reg[6][7:0];
            end
        endcase
        if (smns_pkg::interior(out_pos_reg, w, h))
        begin
            result = (centre > nb_a && centre > nb_b) ? centre : 8'd0;
        end
        else
        begin
            result = centre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            clr_addr_reg  <= '0;
            off_reg       <= '0;
            dc_reg        <= 2'd0;
            idx_reg       <= 4'd0;
            cap_en_reg    <= 1'b0;
            cap_mag_reg   <= 1'b0;
            cap_idx_reg   <= 4'd0;
            bit_reg       <= 3'd0;
            mag_pos_reg   <= '0;
            out_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            cap_en_reg <= ((state_reg == ST_PRD) || (state_reg == ST_MRD))
                          && (idx_reg != 4'd9);
            // drop the taken result unless a new one replaces it this cycle
            if (out_valid_reg && !out_stall && !((state_reg == ST_OUT) && vo_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == RING_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        ptr_reg   <= ptr_inc;
                        off_reg   <= (w_a << 1) + AW'(2);
                        dc_reg    <= 2'd0;
                        idx_reg   <= 4'd0;
                        state_reg <= ST_PRD;
                    end
                end
                ST_PRD, ST_MRD:
                begin
                    cap_mag_reg <= (state_reg == ST_MRD);
                    if (idx_reg != 4'd9)
                    begin
                        cap_idx_reg <= idx_reg;
                        idx_reg     <= idx_reg + 4'd1;
                        if (dc_reg == 2'd2)
                        begin
                            dc_reg  <= 2'd0;
                            off_reg <= off_reg - w_a;
                        end
                        else
                        begin
                            dc_reg <= dc_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= (state_reg == ST_PRD) ? ST_GRAD : ST_OUT;
                    end
                end
                ST_GRAD:
                begin
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    bit_reg   <= 3'd7;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= ST_MWR;
                    end
                end
                ST_MWR:
                begin
                    if (vc_reg)
                    begin
                        mag_pos_reg <= smns_pkg::advance(mag_pos_reg, w, h);
                    end
                    off_reg   <= (w_a << 1) + w_a + AW'(3);
                    dc_reg    <= 2'd0;
                    idx_reg   <= 4'd0;
                    state_reg <= ST_MRD;
                end
                ST_OUT:
                begin
                    if (!vo_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_item_reg.edge_value <= result;
                        out_item_reg.last       <=
                            ({1'b0, out_pos_reg.row} + 13'd1 == {1'b0, h})
                            && ({1'b0, out_pos_reg.col} + 13'd1 == {1'b0, w});
                        out_pos_reg <= smns_pkg::advance(out_pos_reg, w, h);
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en_reg && !cap_mag_reg)
        begin
            p_reg[cap_idx_reg] <= pix_rdata[7:0];
            if (cap_idx_reg == 4'd4)
            begin
                vc_reg <= pix_rdata[8];
            end
            if (cap_idx_reg == 4'd0)
            begin
                vo_reg <= pix_rdata[8];
            end
        end
        if (cap_en_reg && cap_mag_reg)
        begin
            m_reg[cap_idx_reg] <= mag_rdata;
        end
        if (state_reg == ST_GRAD)
        begin
            gx_reg <= gx_calc;
            gy_reg <= gy_calc;
        end
        if (state_reg == ST_SQ)
        begin
            s_reg    <= 21'(20'(ax) * 20'(ax)) + 21'(20'(ay) * 20'(ay));
            sat_reg  <= (21'(20'(ax) * 20'(ax)) + 21'(20'(ay) * 20'(ay))) >= 21'd65536;
            dir_reg  <= dir_calc;
            root_reg <= 8'd0;
        end
        if (state_reg == ST_SQRT && {5'd0, trial_sq} <= s_reg)
        begin
            root_reg <= trial;
        end
    end

    // root is the floor square root once the iteration ends
    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWR && !sat_reg) |-> ({5'd0, 16'(root_reg) * 16'(root_reg)} <= s_reg))
        else $error("square root too large");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWR && !sat_reg)
            |-> ({3'd0, 18'(9'(root_reg) + 9'd1) * 18'(9'(root_reg) + 9'd1)} > s_reg))
        else $error("square root too small");

    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !q_pop |=> $stable(ptr_reg))
        else $error("ring pointer moved without an item");

    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result during clearing pass");

endmodule

/* rtl/sobel_magnitude_nonmax_suppress.sv */
// Channel  Direction  Payload               Handshake
// in       receive    in_item  (kind,pixel) in_valid / in_stall
// out      send       out_item (edge,last)  out_valid / out_stall
// cfg      receive    cfg_index, cfg_data   cfg_we, no wait
//
// Each stream slot runs through the back-end sequencer one at a time: nine
// pixel reads and nine magnitude reads through the single read port of each
// ring memory, the gradient and squaring states and eight square root iterations.
// After reset a clearing pass zeroes all 3*MAX_WIDTH+4 pixel ring entries;
// in_stall stays high for its length. A two-entry queue lets the input side
// take items while the back end works or the output register waits on out_stall.
module sobel_magnitude_nonmax_suppress #(
    parameter int MAX_WIDTH = smns_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  smns_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output smns_pkg::out_item_t         out_item,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [smns_pkg::DIM_W-1:0]  cfg_data
);

    logic [smns_pkg::DIM_W-1:0] width_reg;
    logic [smns_pkg::DIM_W-1:0] height_reg;
    logic [smns_pkg::DIM_W-1:0] eff_w;
    logic [smns_pkg::DIM_W-1:0] eff_h;

    logic            clearing;
    logic            q_valid;
    logic            q_pop;
    smns_pkg::slot_t q_item;

    // hold the frame size; the user must write it only while the block is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= smns_pkg::WIDTH_RST;
            height_reg <= smns_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smns_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                smns_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                    width_reg  <= width_reg;
            endcase
        end
    end

    // clamp the size into the supported range
    always_comb
    begin
        if (width_reg < smns_pkg::DIM_MIN)
        begin
            eff_w = smns_pkg::DIM_MIN;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = smns_pkg::DIM_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        eff_h = (height_reg < smns_pkg::DIM_MIN) ? smns_pkg::DIM_MIN : height_reg;
    end

    // front: count raster position, drop flushes inside a frame, queue slots
    smns_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .w        (eff_w),
        .h        (eff_h),
        .clearing (clearing),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: ring stores, Sobel, square root, suppression, output register
    smns_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .w         (eff_w),
        .h         (eff_h),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
